// ===== rtl/core/msc_pkg.sv =====
package msc_pkg;

  localparam int unsigned DMEM_WORDS_DEF = 1024;
  localparam logic [31:0] START_PC_RST   = 32'h0040_0000;
  localparam int unsigned WIDX_W         = 30;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;

  typedef struct packed {
    logic        mode;
    logic [31:0] instruction;
    logic [9:0]  preload_address;
    logic [31:0] preload_data;
  } in_item_t;

  typedef struct packed {
    logic        halted;
    logic [31:0] next_pc;
    logic        reg_write_valid;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        mem_write_valid;
    logic [9:0]  mem_write_address;
    logic [31:0] mem_write_value;
    logic        unsupported;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

endpackage

// ===== rtl/core/msc_stream_if.sv =====
interface msc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/msc_regfile.sv =====
module msc_regfile (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rd_en_i,
  input  logic [4:0]     rs_addr_i,
  input  logic [4:0]     rt_addr_i,
  input  msc_pkg::rf_wr_t wr_i,
  output logic [31:0]    rs_data_o,
  output logic [31:0]    rt_data_o
);

  logic [31:0] mem [32];
  logic [31:0] vld_q;
  logic        rs_vld_q;
  logic        rt_vld_q;
  logic [31:0] rs_raw_q;
  logic [31:0] rt_raw_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rs_raw_q <= mem[rs_addr_i];
      rt_raw_q <= mem[rt_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rs_vld_q <= 1'b0;
      rt_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rs_vld_q <= vld_q[rs_addr_i];
        rt_vld_q <= vld_q[rt_addr_i];
      end
    end
  end

  assign rs_data_o = rs_vld_q ? rs_raw_q : '0;
  assign rt_data_o = rt_vld_q ? rt_raw_q : '0;

endmodule

// ===== rtl/core/msc_dmem.sv =====
module msc_dmem #(
  parameter int unsigned DMEM_WORDS = msc_pkg::DMEM_WORDS_DEF,
  localparam int unsigned AW = $clog2(DMEM_WORDS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] addr_i,
  input  logic [31:0]   wr_data_i,
  output logic [31:0]   rd_data_o,
  output logic          clr_busy_o
);

  localparam logic [AW-1:0] LAST = AW'(DMEM_WORDS - 1);

  logic [31:0]   mem [DMEM_WORDS];
  logic [31:0]   rd_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == LAST) begin
        clr_busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign rd_data_o  = rd_q;
  assign clr_busy_o = clr_busy_q;

endmodule

// ===== rtl/core/msc_widx.sv =====
module msc_widx #(
  parameter int unsigned DMEM_WORDS = msc_pkg::DMEM_WORDS_DEF,
  localparam int unsigned AW = $clog2(DMEM_WORDS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [msc_pkg::WIDX_W-1:0]   value_i,
  output logic                         done_o,
  output logic [AW-1:0]                rem_o
);

  localparam bit POW2 = (DMEM_WORDS & (DMEM_WORDS - 1)) == 0;

  if (POW2) begin : g_mask
    logic          done_q;
    logic [AW-1:0] rem_q;

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= value_i[AW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end else begin : g_recip
    // The quotient comes from a rounded-up reciprocal, exact for every 30-bit value.
    localparam int unsigned QW = msc_pkg::WIDX_W + 1 - AW;
    localparam int unsigned PW = 2 * msc_pkg::WIDX_W + 1;
    localparam longint unsigned RECIP_L =
      ((64'd1 << (msc_pkg::WIDX_W + AW)) + 64'(DMEM_WORDS) - 64'd1) / 64'(DMEM_WORDS);
    localparam logic [msc_pkg::WIDX_W:0] RECIP = (msc_pkg::WIDX_W + 1)'(RECIP_L);
    localparam logic [AW-1:0] MODV = AW'(DMEM_WORDS);

    logic                       s0_q;
    logic                       s1_q;
    logic                       s2_q;
    logic                       done_q;
    logic [msc_pkg::WIDX_W-1:0] val_q;
    logic [PW-1:0]              prod_q;
    logic [QW-1:0]              quot;
    logic [msc_pkg::WIDX_W:0]   qm_full;
    logic [AW-1:0]              qm_q;
    logic [AW-1:0]              rem_q;

    always_comb begin
      quot    = prod_q[PW-1:PW-QW];
      qm_full = {{AW{1'b0}}, quot} * {{QW{1'b0}}, MODV};
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        val_q <= value_i;
      end
      if (s0_q) begin
        prod_q <= {{(msc_pkg::WIDX_W + 1){1'b0}}, val_q} * {{msc_pkg::WIDX_W{1'b0}}, RECIP};
      end
      if (s1_q) begin
        qm_q <= qm_full[AW-1:0];
      end
      if (s2_q) begin
        rem_q <= val_q[AW-1:0] - qm_q;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s0_q   <= 1'b0;
        s1_q   <= 1'b0;
        s2_q   <= 1'b0;
        done_q <= 1'b0;
      end else begin
        s0_q   <= start_i;
        s1_q   <= s0_q;
        s2_q   <= s1_q;
        done_q <= s2_q;
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end

endmodule

// ===== rtl/core/mips_subset_single_cycle_core.sv =====
// Executes a subset of the MIPS instruction set, one instruction per transaction.
// in_i carries one item: in execute mode an instruction word, in preload mode a
// data memory word and its word index. Every item yields exactly one result
// transaction on out_o with the program counter and any register or memory
// write of an instruction. cfg_i writes a start address register that reset
// sets to START_PC_RST before the program counter loads it. An accepted item
// is decoded in S_DEC, which registers the result. Loads, stores and preloads
// also pass the word index unit in S_ADDR and the data memory in S_MEM, loads
// also S_LOAD. When DMEM_WORDS is not a power of two the index unit reduces the
// address by a reciprocal multiplication. The next item is taken once the previous
// result sits in the output register. After reset the data memory is cleared one
// word per cycle, all DMEM_WORDS words, while in_i stays not ready; cfg_i is
// always ready. The register file clears at once. A stalled out_o holds its
// result, and the core waits with the next one until the output register is free.
module mips_subset_single_cycle_core #(
  parameter int unsigned DMEM_WORDS = msc_pkg::DMEM_WORDS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  msc_stream_if.sink          in_i,
  msc_stream_if.source        out_o,
  msc_stream_if.sink          cfg_i
);

  localparam int unsigned AW = $clog2(DMEM_WORDS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_MEM  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0]             state_q, state_d;
  msc_pkg::in_item_t      item_q;
  msc_pkg::out_item_t     out_q, res;
  logic                   out_valid_q;
  logic [31:0]            pc_q, pc_d;
  logic                   pc_init_q;
  logic                   stopped_q, stopped_d;
  logic [31:0]            start_pc_q;

  logic                   in_acc;
  logic                   slot_free;
  logic                   fin;
  msc_pkg::rf_wr_t        rf_wr;
  logic [31:0]            a, b;
  logic                   mod_start, mod_done;
  logic [msc_pkg::WIDX_W-1:0] mod_val;
  logic [AW-1:0]          mod_rem;
  logic [31:0]            idx_wide;
  logic                   dm_rd, dm_wr, clr_busy;
  logic [31:0]            dm_wdata, dm_rdata;

  logic [5:0]             op, fn;
  logic [4:0]             rs, rt, rd;
  logic [31:0]            simm, pc4, addr_sum;
  logic                   alu_rw, alu_bad;
  logic [4:0]             alu_dst;
  logic [31:0]            alu_val, alu_npc;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE) && !clr_busy && !pc_init_q;
  assign cfg_i.ready = 1'b1;
  assign slot_free   = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign op       = item_q.instruction[31:26];
  assign rs       = item_q.instruction[25:21];
  assign rt       = item_q.instruction[20:16];
  assign rd       = item_q.instruction[15:11];
  assign fn       = item_q.instruction[5:0];
  assign simm     = {{16{item_q.instruction[15]}}, item_q.instruction[15:0]};
  assign pc4      = pc_q + 32'd4;
  assign addr_sum = a + simm;
  assign idx_wide = 32'(mod_rem);

  msc_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rs_addr_i (in_i.data.instruction[25:21]),
    .rt_addr_i (in_i.data.instruction[20:16]),
    .wr_i      (rf_wr),
    .rs_data_o (a),
    .rt_data_o (b)
  );

  msc_widx #(
    .DMEM_WORDS (DMEM_WORDS)
  ) u_widx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (mod_val),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  msc_dmem #(
    .DMEM_WORDS (DMEM_WORDS)
  ) u_dmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (dm_rd),
    .wr_en_i    (dm_wr),
    .addr_i     (mod_rem),
    .wr_data_i  (dm_wdata),
    .rd_data_o  (dm_rdata),
    .clr_busy_o (clr_busy)
  );

  always_comb begin
    alu_rw  = 1'b0;
    alu_bad = 1'b0;
    alu_dst = rt;
    alu_val = '0;
    alu_npc = pc4;
    case (op)
      msc_pkg::OP_RTYPE: begin
        alu_dst = rd;
        alu_rw  = 1'b1;
        if (fn == msc_pkg::FN_ADD || fn == msc_pkg::FN_ADDU) begin
          alu_val = a + b;
        end else if (fn == msc_pkg::FN_SUB || fn == msc_pkg::FN_SUBU) begin
          alu_val = a - b;
        end else if (fn == msc_pkg::FN_AND) begin
          alu_val = a & b;
        end else begin
          alu_rw  = 1'b0;
          alu_bad = 1'b1;
        end
      end
      msc_pkg::OP_J: begin
        alu_npc = {pc4[31:28], item_q.instruction[25:0], 2'b00};
      end
      msc_pkg::OP_BGTZ: begin
        if (a != '0 && !a[31]) begin
          alu_npc = pc4 + {simm[29:0], 2'b00};
        end
      end
      msc_pkg::OP_ADDI, msc_pkg::OP_ADDIU: begin
        alu_rw  = 1'b1;
        alu_val = addr_sum;
      end
      default: begin
        alu_bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    fin       = 1'b0;
    res       = '0;
    res.halted  = stopped_q;
    res.next_pc = pc_q;
    pc_d      = pc_q;
    stopped_d = stopped_q;
    rf_wr     = '0;
    mod_start = 1'b0;
    mod_val   = '0;
    dm_rd     = 1'b0;
    dm_wr     = 1'b0;
    dm_wdata  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (item_q.mode) begin
          mod_start = 1'b1;
          mod_val   = msc_pkg::WIDX_W'(item_q.preload_address);
          state_d   = S_ADDR;
        end else if (stopped_q) begin
          fin = slot_free;
        end else if (item_q.instruction == '0) begin
          fin         = slot_free;
          res.halted  = 1'b1;
          res.next_pc = pc4;
          pc_d        = pc4;
          stopped_d   = 1'b1;
        end else if (op == msc_pkg::OP_LW || op == msc_pkg::OP_SW) begin
          mod_start = 1'b1;
          mod_val   = addr_sum[31:2];
          state_d   = S_ADDR;
        end else begin
          fin             = slot_free;
          res.next_pc     = alu_npc;
          pc_d            = alu_npc;
          res.unsupported = alu_bad;
          if (alu_rw && alu_dst != '0) begin
            res.reg_write_valid = 1'b1;
            res.reg_write_index = alu_dst;
            res.reg_write_value = alu_val;
            rf_wr.en   = slot_free;
            rf_wr.idx  = alu_dst;
            rf_wr.data = alu_val;
          end
        end
      end
      S_ADDR: begin
        if (mod_done) begin
          state_d = S_MEM;
        end
      end
      S_MEM: begin
        if (item_q.mode) begin
          fin      = slot_free;
          dm_wr    = slot_free;
          dm_wdata = item_q.preload_data;
        end else if (op == msc_pkg::OP_SW) begin
          fin                   = slot_free;
          dm_wr                 = slot_free;
          dm_wdata              = b;
          res.next_pc           = pc4;
          pc_d                  = pc4;
          res.mem_write_valid   = 1'b1;
          res.mem_write_address = idx_wide[9:0];
          res.mem_write_value   = b;
        end else begin
          dm_rd   = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        fin         = slot_free;
        res.next_pc = pc4;
        pc_d        = pc4;
        if (rt != '0) begin
          res.reg_write_valid = 1'b1;
          res.reg_write_index = rt;
          res.reg_write_value = dm_rdata;
          rf_wr.en   = slot_free;
          rf_wr.idx  = rt;
          rf_wr.data = dm_rdata;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_i.data;
    end
    if (fin) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pc_q        <= msc_pkg::START_PC_RST;
      pc_init_q   <= 1'b1;
      stopped_q   <= 1'b0;
      start_pc_q  <= msc_pkg::START_PC_RST;
    end else begin
      state_q   <= state_d;
      pc_init_q <= 1'b0;
      if (cfg_i.valid) begin
        start_pc_q <= cfg_i.data;
      end
      if (pc_init_q) begin
        pc_q <= start_pc_q;
      end else if (fin) begin
        pc_q      <= pc_d;
        stopped_q <= stopped_d;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_zero_reg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.data.reg_write_valid && out_o.data.reg_write_index == '0))
    else $error("result reports a write to register zero");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("halted state cleared without reset");

  a_unsup_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.unsupported |->
      !out_o.data.reg_write_valid && !out_o.data.mem_write_valid)
    else $error("unsupported instruction caused a write");

  a_idx_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == S_ADDR)
    else $error("word index result arrived outside the address phase");

  a_preload_no_rf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin && item_q.mode |-> !rf_wr.en)
    else $error("preload transaction wrote the register file");
`endif

endmodule
